@@ rtl/jls_pkg.sv @@
// Shared widths, register indexes and the position tag type of the Jacobi sweep block.
package jls_pkg;

  localparam int COLS_W     = 11;
  localparam int ROWS_W     = 16;
  localparam int ROW_CNT_W  = 17;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 24;
  localparam int TOL_W_MAX  = 24;

  localparam logic [CFG_IDX_W-1:0] REG_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROWS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOL  = 2'd2;

  localparam logic [COLS_W-1:0] COLS_RESET = 11'd1024;
  localparam logic [ROWS_W-1:0] ROWS_RESET = 16'd1024;

  typedef struct packed {
    logic              interior;
    logic              last;
    logic              restart;
    logic [ROWS_W-1:0] row_idx;
    logic [COLS_W-1:0] col_idx;
  } pos_tag_t;

endpackage

@@ rtl/jls_line_mem.sv @@
// Line buffer memory: one write port and two registered read ports.
module jls_line_mem #(
  parameter int WORD_W = 48,
  parameter int DEPTH  = 1026,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [AW-1:0]     waddr_i,
  input  logic [WORD_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [AW-1:0]     raddr_a_i,
  input  logic [AW-1:0]     raddr_b_i,
  output logic [WORD_W-1:0] rdata_a_o,
  output logic [WORD_W-1:0] rdata_b_o
);

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rdata_a_q;
  logic [WORD_W-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem[raddr_a_i];
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

@@ rtl/jls_scan.sv @@
// Configuration registers and raster position tracking of the input stream.
module jls_scan import jls_pkg::*; #(
  parameter int MAX_COLUMNS = 1024,
  parameter int VALUE_BITS  = 24,
  parameter int FRAC_BITS   = 16,
  localparam int CW = $clog2(MAX_COLUMNS + 2),
  localparam int TW = (VALUE_BITS < TOL_W_MAX) ? VALUE_BITS : TOL_W_MAX
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  accept_i,
  output logic [CW-1:0]         addr_o,
  output logic [CW-1:0]         addr_next_o,
  output pos_tag_t              tag_o,
  output logic [TW-1:0]         tol_o
);

  localparam int EW = (CW + 1 > COLS_W) ? CW + 1 : COLS_W;
  localparam logic [63:0] TolFull = (64'd1 << FRAC_BITS) / 64'd100;
  localparam logic [CW-1:0] LastAddr = CW'(MAX_COLUMNS + 1);

  logic [COLS_W-1:0]    cols_q;
  logic [ROWS_W-1:0]    rows_q;
  logic [TW-1:0]        tol_q;
  logic [CW-1:0]        col_q, col_d;
  logic [ROW_CNT_W-1:0] row_q, row_d;
  logic                 pend_q, pend_d;

  logic [EW-1:0]        cols_ext, cols_eff, width_w, col_cur_e, col_next_e;
  logic [ROW_CNT_W-1:0] rows_eff, height, row_a, row_cur, row_b;
  logic [CW-1:0]        col_cur;
  logic                 pre_cw, pre_rw, post_cw, post_rw;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q <= COLS_RESET;
      rows_q <= ROWS_RESET;
      tol_q  <= TolFull[TW-1:0];
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_COLS: cols_q <= cfg_wdata_i[COLS_W-1:0];
        REG_ROWS: rows_q <= cfg_wdata_i[ROWS_W-1:0];
        REG_TOL:  tol_q  <= cfg_wdata_i[TW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cols_ext = EW'(cols_q);
    if (cols_ext == '0) begin
      cols_eff = EW'(1);
    end else if (cols_ext > EW'(MAX_COLUMNS)) begin
      cols_eff = EW'(MAX_COLUMNS);
    end else begin
      cols_eff = cols_ext;
    end
    rows_eff = (rows_q == '0) ? ROW_CNT_W'(1) : ROW_CNT_W'(rows_q);
    width_w  = cols_eff + EW'(2);
    height   = rows_eff + ROW_CNT_W'(2);

    // wrap a position left stale by a size change
    pre_cw    = EW'(col_q) >= width_w;
    col_cur   = pre_cw ? '0 : col_q;
    row_a     = pre_cw ? row_q + ROW_CNT_W'(1) : row_q;
    pre_rw    = row_a >= height;
    row_cur   = pre_rw ? '0 : row_a;
    col_cur_e = EW'(col_cur);

    tag_o.interior = (row_cur >= ROW_CNT_W'(2)) && (col_cur_e != '0) &&
                     (col_cur_e <= cols_eff);
    tag_o.last     = (row_cur == rows_eff + ROW_CNT_W'(1)) && (col_cur_e == cols_eff);
    tag_o.restart  = pend_q | pre_rw;
    tag_o.row_idx  = ROWS_W'(row_cur - ROW_CNT_W'(1));
    tag_o.col_idx  = COLS_W'(col_cur);

    // advance to the next raster position
    col_next_e = col_cur_e + EW'(1);
    post_cw    = col_next_e >= width_w;
    col_d      = post_cw ? '0 : col_next_e[CW-1:0];
    row_b      = post_cw ? row_cur + ROW_CNT_W'(1) : row_cur;
    post_rw    = row_b >= height;
    row_d      = post_rw ? '0 : row_b;
    pend_d     = post_rw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= '0;
      row_q  <= '0;
      pend_q <= 1'b0;
    end else if (accept_i) begin
      col_q  <= col_d;
      row_q  <= row_d;
      pend_q <= pend_d;
    end
  end

  assign addr_o      = col_cur;
  assign addr_next_o = (col_cur == LastAddr) ? col_cur : col_cur + CW'(1);
  assign tol_o       = tol_q;

endmodule

@@ rtl/jls_stencil.sv @@
// Five-point stencil stage: neighbor average, change, running maximum and result register.
module jls_stencil import jls_pkg::*; #(
  parameter int VALUE_BITS = 24,
  parameter int ADDR_W     = 11,
  parameter int TOL_W      = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    accept_i,
  output logic                    in_ready_o,
  input  logic [VALUE_BITS-1:0]   cell_value_i,
  input  logic [ADDR_W-1:0]       addr_i,
  input  pos_tag_t                tag_i,
  input  logic [TOL_W-1:0]        tol_i,
  input  logic [2*VALUE_BITS-1:0] rd_centre_i,
  input  logic [2*VALUE_BITS-1:0] rd_right_i,
  output logic                    wr_en_o,
  output logic [ADDR_W-1:0]       wr_addr_o,
  output logic [2*VALUE_BITS-1:0] wr_data_o,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic [VALUE_BITS-1:0]   new_value_o,
  output logic [VALUE_BITS-1:0]   abs_change_o,
  output logic [VALUE_BITS-1:0]   sweep_max_change_o,
  output logic [ROWS_W-1:0]       row_index_o,
  output logic [COLS_W-1:0]       col_index_o,
  output logic                    end_of_sweep_o,
  output logic                    converged_o
);

  localparam int V = VALUE_BITS;

  logic          s1_valid_q, s1_valid_d;
  logic [V-1:0]  s1_v_q;
  logic [ADDR_W-1:0] s1_addr_q;
  pos_tag_t      s1_tag_q;
  logic [V-1:0]  left_q;
  logic [V-1:0]  max_q, max_d;
  logic          out_valid_q;

  logic [V-1:0]  nv_q, diff_q, omax_q;
  pos_tag_t      otag_q;
  logic          conv_q;

  logic [V-1:0]  up, centre, right, nv, diff, max_base;
  logic [V+1:0]  sum;
  logic          emit, out_free, s1_adv, conv;

  assign up     = rd_centre_i[2*V-1:V];
  assign centre = rd_centre_i[V-1:0];
  assign right  = rd_right_i[V-1:0];

  assign out_free   = !out_valid_q || out_ready_i;
  assign emit       = s1_valid_q && s1_tag_q.interior;
  assign s1_adv     = s1_valid_q && (!s1_tag_q.interior || out_free);
  assign in_ready_o = !s1_valid_q || s1_adv;

  always_comb begin
    sum = (V+2)'(up) + (V+2)'(s1_v_q) + (V+2)'(left_q) + (V+2)'(right);
    nv  = sum[V+1:2];
    diff = (nv >= centre) ? nv - centre : centre - nv;
    // a new sweep starts with its maximum cleared
    max_base = s1_tag_q.restart ? '0 : max_q;
    max_d    = (emit && diff > max_base) ? diff : max_base;
    conv     = s1_tag_q.last && (max_d <= V'(tol_i));
    s1_valid_d = accept_i ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_q);
  end

  // the item leaving the stage shifts its column down one line
  assign wr_en_o   = s1_adv;
  assign wr_addr_o = s1_addr_q;
  assign wr_data_o = {centre, s1_v_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_tag_q    <= '0;
      max_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (accept_i) begin
        s1_tag_q <= tag_i;
      end
      if (s1_adv) begin
        max_q <= max_d;
      end
      if (s1_adv && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_v_q    <= cell_value_i;
      s1_addr_q <= addr_i;
    end
    if (s1_adv) begin
      left_q <= centre;
    end
    if (s1_adv && emit) begin
      nv_q   <= nv;
      diff_q <= diff;
      omax_q <= max_d;
      otag_q <= s1_tag_q;
      conv_q <= conv;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign new_value_o        = nv_q;
  assign abs_change_o       = diff_q;
  assign sweep_max_change_o = omax_q;
  assign row_index_o        = otag_q.row_idx;
  assign col_index_o        = otag_q.col_idx;
  assign end_of_sweep_o     = otag_q.last;
  assign converged_o        = conv_q;

`ifndef SYNTH
  a_conv_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && converged_o |-> end_of_sweep_o)
    else $error("converged flagged off the end of a sweep");

  a_max_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> sweep_max_change_o >= abs_change_o)
    else $error("sweep maximum below the cell change");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && s1_tag_q.interior && out_valid_q)
    else $error("input stalled without a blocked result");

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> s1_valid_q && $stable(s1_addr_q))
    else $error("stalled stencil item lost");
`endif

endmodule

@@ rtl/jacobi_laplace_sweep.sv @@
// Top level of the streaming Jacobi sweep over a Laplace grid with boundary ring.
// A taken input word is held in the input stage register and then loads the result register.
// Throughput: one word per cycle; an interior word in the input stage waits only while
//   a held result word is not taken. Line memory: two reads and one write a cycle.
// Reset clears position, running maximum and handshake state, not line memory;
// configuration returns to 1024 columns, 1024 rows and a tolerance of about 0.01.
module jacobi_laplace_sweep import jls_pkg::*; #(
  parameter int MAX_COLUMNS = 1024,
  parameter int VALUE_BITS  = 24,
  parameter int FRAC_BITS   = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [VALUE_BITS-1:0] cell_value_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [VALUE_BITS-1:0] new_value_o,
  output logic [VALUE_BITS-1:0] abs_change_o,
  output logic [VALUE_BITS-1:0] sweep_max_change_o,
  output logic [ROWS_W-1:0]     row_index_o,
  output logic [COLS_W-1:0]     col_index_o,
  output logic                  end_of_sweep_o,
  output logic                  converged_o
);

  // Column addresses cover the interior plus both boundary columns.
  localparam int DEPTH = MAX_COLUMNS + 2;
  localparam int CW    = $clog2(DEPTH);
  localparam int TW    = (VALUE_BITS < TOL_W_MAX) ? VALUE_BITS : TOL_W_MAX;
  localparam int WW    = 2 * VALUE_BITS;

  logic          accept;
  logic [CW-1:0] addr, addr_next;
  pos_tag_t      tag;
  logic [TW-1:0] tol;
  logic [WW-1:0] rd_centre, rd_right;
  logic          wr_en;
  logic [CW-1:0] wr_addr;
  logic [WW-1:0] wr_data;

  assign accept = in_valid_i && in_ready_o;

  // Raster position of each incoming word and the size/tolerance registers.
  jls_scan #(
    .MAX_COLUMNS (MAX_COLUMNS),
    .VALUE_BITS  (VALUE_BITS),
    .FRAC_BITS   (FRAC_BITS)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .accept_i    (accept),
    .addr_o      (addr),
    .addr_next_o (addr_next),
    .tag_o       (tag),
    .tol_o       (tol)
  );

  // Each memory word holds one column: the row two above in the upper half, the row
  // just above in the lower half. Port A reads the word under the cell, port B the
  // word to its right; both are captured only when a word is taken.
  jls_line_mem #(
    .WORD_W (WW),
    .DEPTH  (DEPTH)
  ) u_line_mem (
    .clk_i     (clk_i),
    .we_i      (wr_en),
    .waddr_i   (wr_addr),
    .wdata_i   (wr_data),
    .re_i      (accept),
    .raddr_a_i (addr),
    .raddr_b_i (addr_next),
    .rdata_a_o (rd_centre),
    .rdata_b_o (rd_right)
  );

  // Average, change and running maximum, then the result register.
  jls_stencil #(
    .VALUE_BITS (VALUE_BITS),
    .ADDR_W     (CW),
    .TOL_W      (TW)
  ) u_stencil (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .accept_i           (accept),
    .in_ready_o         (in_ready_o),
    .cell_value_i       (cell_value_i),
    .addr_i             (addr),
    .tag_i              (tag),
    .tol_i              (tol),
    .rd_centre_i        (rd_centre),
    .rd_right_i         (rd_right),
    .wr_en_o            (wr_en),
    .wr_addr_o          (wr_addr),
    .wr_data_o          (wr_data),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .new_value_o        (new_value_o),
    .abs_change_o       (abs_change_o),
    .sweep_max_change_o (sweep_max_change_o),
    .row_index_o        (row_index_o),
    .col_index_o        (col_index_o),
    .end_of_sweep_o     (end_of_sweep_o),
    .converged_o        (converged_o)
  );

endmodule
